// ----- design/iqla_pkg.sv -----
`timescale 1ns / 1ps

package iqla_pkg;

  // Delay line
  localparam int DELAY_DEPTH = 256;
  localparam int DAW = $clog2(DELAY_DEPTH);

  // Queue between front and back
  localparam int QDEPTH = 4;
  localparam int QAW = $clog2(QDEPTH);
  localparam int QLW = $clog2(QDEPTH + 1);

  // Fixed constants
  localparam logic [31:0] GAIN_FLOOR = 32'd41943;     // 0.01 in Q10.22
  localparam logic [15:0] STORE_FILL = 16'd328;       // 0.01 in Q1.15
  localparam logic [15:0] PEAK_INIT  = 16'd32768;     // 1.0 in Q1.15
  localparam logic [31:0] GAIN_INIT  = 32'd4194304;   // 1.0 in Q10.22

  // Register reset values
  localparam logic [30:0] ATTACK_INIT  = 31'd1070313367;
  localparam logic [30:0] RELEASE_INIT = 31'd1073793333;
  localparam logic [30:0] DECAY_INIT   = 31'd1073535805;
  localparam logic [31:0] MAXG_INIT    = 32'd4194304000;
  localparam logic [15:0] TARGET_INIT  = 16'd16384;

  localparam int CFG_IW = 3;

  typedef enum logic [CFG_IW-1:0] {
    REG_ATTACK  = 3'd0,
    REG_RELEASE = 3'd1,
    REG_DECAY   = 3'd2,
    REG_MAXG    = 3'd3,
    REG_TARGET  = 3'd4
  } cfg_reg_t;

  typedef struct packed {
    logic [30:0] attack_ramp;
    logic [30:0] release_ramp;
    logic [30:0] envelope_decay;
    logic [31:0] max_gain;
    logic [15:0] target_level;
  } cfg_t;

  // One queued item: |I| of the new sample and the delayed I/Q pair
  typedef struct packed {
    logic [15:0] mag_in;
    logic [15:0] dly_i;
    logic [15:0] dly_q;
  } item_t;

  typedef struct packed {
    logic  valid;
    item_t item;
  } push_t;

  typedef struct packed {
    logic           nonempty;
    logic [QLW-1:0] level;
  } q_stat_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DECAY,
    ST_PEAK,
    ST_LEVEL,
    ST_DIR,
    ST_RAMP,
    ST_CLAMP,
    ST_APPLY,
    ST_DONE
  } back_state_t;

endpackage

// ----- design/iq_lookahead_agc_top.sv -----
`timescale 1ns / 1ps

// Channel   Ports                            Contents
// input     s_tvalid s_tready s_tdata[31:0]  in_i, in_q
// output    m_tvalid m_tready m_tdata[63:0]  out_i, out_q, gain_now
// config    cfg_valid cfg_ready cfg_index    register writes, always ready
//           cfg_data[31:0]
//
// Each item steps through the back-end sequencer states DECAY, PEAK, LEVEL, DIR, RAMP,
// CLAMP, APPLY and DONE, running the envelope, level, gain and out_i products through one
// shared multiplier, out_q through its own; that sequencer sets the rate.
// The front writes the delay memory and queues up to 4 items, so input keeps flowing
// while a result waits on m_tready. Reset is synchronous; the delay memory is not
// cleared, a fill count substitutes the reset fill for entries not yet written.

module iq_lookahead_agc_top import iqla_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              s_tvalid,
  output logic              s_tready,
  input  logic [31:0]       s_tdata,    // [15:0] in_i, [31:16] in_q
  output logic              m_tvalid,
  input  logic              m_tready,
  output logic [63:0]       m_tdata,    // [15:0] out_i, [31:16] out_q, [63:32] gain_now
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [CFG_IW-1:0] cfg_index,
  input  logic [31:0]       cfg_data
);

  cfg_t    cfg;
  push_t   push;
  item_t   head;
  q_stat_t q_stat;
  logic    pop;

  assign cfg_ready = 1'b1;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.attack_ramp    <= ATTACK_INIT;
      cfg.release_ramp   <= RELEASE_INIT;
      cfg.envelope_decay <= DECAY_INIT;
      cfg.max_gain       <= MAXG_INIT;
      cfg.target_level   <= TARGET_INIT;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_reg_t'(cfg_index))
        REG_ATTACK:  cfg.attack_ramp    <= cfg_data[30:0];
        REG_RELEASE: cfg.release_ramp   <= cfg_data[30:0];
        REG_DECAY:   cfg.envelope_decay <= cfg_data[30:0];
        REG_MAXG:    cfg.max_gain       <= cfg_data;
        REG_TARGET:  cfg.target_level   <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  iqla_front u_front (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .q_stat   (q_stat),
    .push     (push)
  );

  iqla_queue u_queue (
    .clk    (clk),
    .rst    (rst),
    .push   (push),
    .pop    (pop),
    .head   (head),
    .q_stat (q_stat)
  );

  iqla_back u_back (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .head     (head),
    .q_stat   (q_stat),
    .pop      (pop),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  // Delivered gain never falls below the floor
  a_gain_floor: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[63:32] >= GAIN_FLOOR))
    else $error("gain below floor");

  // Queue never overfills
  a_q_bound: assert property (@(posedge clk) disable iff (rst)
    q_stat.level <= QLW'(QDEPTH))
    else $error("queue overflow");

  // Full queue blocks input
  a_full_block: assert property (@(posedge clk) disable iff (rst)
    (q_stat.level == QLW'(QDEPTH)) |-> !s_tready)
    else $error("input accepted with full queue");

  // Pop only from a nonempty queue
  a_pop_nonempty: assert property (@(posedge clk) disable iff (rst)
    pop |-> q_stat.nonempty)
    else $error("pop from empty queue");

endmodule

// ----- design/iqla_front.sv -----
`timescale 1ns / 1ps

module iqla_front import iqla_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,   // [15:0] in_i, [31:16] in_q
  input  q_stat_t     q_stat,
  output push_t       push
);

  logic [15:0] mem_i [DELAY_DEPTH];
  logic [15:0] mem_q [DELAY_DEPTH];

  logic [DAW-1:0] wp;
  logic [DAW-1:0] rp;
  logic [DAW-1:0] fill;
  logic           pend;
  logic [15:0]    rd_i;
  logic [15:0]    rd_q;
  logic [15:0]    mag;
  logic           stale;

  logic           accept;
  logic [15:0]    in_i;
  logic [15:0]    in_q;
  logic [15:0]    abs_i;
  logic           filled;

  function automatic logic [DAW-1:0] next_ptr(input logic [DAW-1:0] p);
    next_ptr = (p == DAW'(DELAY_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  assign in_i   = s_tdata[15:0];
  assign in_q   = s_tdata[31:16];
  assign abs_i  = in_i[15] ? (~in_i + 16'd1) : in_i;
  assign filled = (fill == DAW'(DELAY_DEPTH - 1));

  // Room for the item in flight plus the new one
  assign s_tready = (({1'b0, q_stat.level} + (QLW+1)'(pend)) < (QLW+1)'(QDEPTH));
  assign accept   = s_tvalid & s_tready;

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wp   <= DAW'(DELAY_DEPTH - 1);
      rp   <= '0;
      fill <= '0;
      pend <= 1'b0;
    end else begin
      pend <= accept;
      if (accept) begin
        wp <= next_ptr(wp);
        rp <= next_ptr(rp);
        if (!filled) begin
          fill <= fill + 1'b1;
        end
      end
    end
  end

  // Delay memory: write new sample, read the one from DELAY_DEPTH-1 items ago
  always_ff @(posedge clk) begin
    if (accept) begin
      mem_i[wp] <= in_i;
      mem_q[wp] <= in_q;
      rd_i      <= mem_i[rp];
      rd_q      <= mem_q[rp];
      mag       <= abs_i;
      stale     <= !filled;
    end
  end

  // Entries never written read as the reset fill
  assign push.valid       = pend;
  assign push.item.mag_in = mag;
  assign push.item.dly_i  = stale ? STORE_FILL : rd_i;
  assign push.item.dly_q  = stale ? STORE_FILL : rd_q;

endmodule

// ----- design/iqla_queue.sv -----
`timescale 1ns / 1ps

module iqla_queue import iqla_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  push_t   push,
  input  logic    pop,
  output item_t   head,
  output q_stat_t q_stat
);

  item_t          slots [QDEPTH];
  logic [QAW-1:0] rd_ptr;
  logic [QAW-1:0] wr_ptr;
  logic [QLW-1:0] level;

  function automatic logic [QAW-1:0] q_next(input logic [QAW-1:0] p);
    q_next = (p == QAW'(QDEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_ptr <= '0;
      wr_ptr <= '0;
      level  <= '0;
    end else begin
      if (push.valid) begin
        wr_ptr <= q_next(wr_ptr);
      end
      if (pop) begin
        rd_ptr <= q_next(rd_ptr);
      end
      level <= level + QLW'(push.valid) - QLW'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push.valid) begin
      slots[wr_ptr] <= push.item;
    end
  end

  assign head            = slots[rd_ptr];
  assign q_stat.nonempty = (level != '0);
  assign q_stat.level    = level;

endmodule

// ----- design/iqla_back.sv -----
`timescale 1ns / 1ps

module iqla_back import iqla_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  cfg_t        cfg,
  input  item_t       head,
  input  q_stat_t     q_stat,
  output logic        pop,
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [63:0] m_tdata    // [15:0] out_i, [31:16] out_q, [63:32] gain_now
);

  back_state_t state;
  back_state_t state_next;

  item_t       cur;
  logic [15:0] peak;
  logic [31:0] gain;
  logic [62:0] prod;
  logic [47:0] prod_q;
  logic        over;

  logic        out_free;
  logic        deliver;
  logic [31:0] mul_a;
  logic [30:0] mul_b;
  logic [62:0] mul_p;

  logic [47:0] env_rnd;
  logic [15:0] env_dec;
  logic [15:0] env_new;
  logic [63:0] g_rnd;
  logic [33:0] g_full;
  logic [31:0] g_max;
  logic [31:0] g_new;
  logic [15:0] mag_di;
  logic [15:0] mag_dq;
  logic [15:0] sat_i;
  logic [15:0] sat_q;

  // Round Q.22 product to nearest (ties away from zero), saturate to Q1.15
  function automatic logic [15:0] sat_out(input logic neg, input logic [47:0] p);
    logic [48:0] r;
    logic [26:0] q;
    logic [16:0] qq;
    r = {1'b0, p} + 49'h200000;
    q = r[48:22];
    if (neg) begin
      qq = (q > 27'd32768) ? 17'd32768 : q[16:0];
      sat_out = 16'(17'h10000 - qq);
    end else begin
      sat_out = (q > 27'd32767) ? 16'h7FFF : q[15:0];
    end
  endfunction

  assign out_free = !m_tvalid || m_tready;
  assign deliver  = (state == ST_DONE) && out_free;

  // Shared multiplier operand select
  always_comb begin
    case (state)
      ST_DECAY: begin
        mul_a = {16'b0, peak};
        mul_b = cfg.envelope_decay;
      end
      ST_LEVEL: begin
        mul_a = gain;
        mul_b = {15'b0, peak};
      end
      ST_RAMP: begin
        mul_a = gain;
        mul_b = over ? cfg.attack_ramp : cfg.release_ramp;
      end
      ST_APPLY: begin
        mul_a = gain;
        mul_b = {15'b0, mag_di};
      end
      default: begin
        mul_a = gain;
        mul_b = '0;
      end
    endcase
  end

  assign mul_p = {31'b0, mul_a} * {32'b0, mul_b};

  // Envelope decay with rounding and saturation
  assign env_rnd = prod[47:0] + 48'h2000_0000;
  assign env_dec = (env_rnd[47:46] != 2'b00) ? 16'hFFFF : env_rnd[45:30];
  assign env_new = (cur.mag_in > peak) ? cur.mag_in : env_dec;

  // Gain rounding and clamp; floor wins over max
  assign g_rnd  = {1'b0, prod} + 64'h2000_0000;
  assign g_full = g_rnd[63:30];
  assign g_max  = (g_full > {2'b0, cfg.max_gain}) ? cfg.max_gain : g_full[31:0];
  assign g_new  = (g_max < GAIN_FLOOR) ? GAIN_FLOOR : g_max;

  // Magnitudes of the delayed pair
  assign mag_di = cur.dly_i[15] ? (~cur.dly_i + 16'd1) : cur.dly_i;
  assign mag_dq = cur.dly_q[15] ? (~cur.dly_q + 16'd1) : cur.dly_q;

  assign sat_i = sat_out(cur.dly_i[15], prod[47:0]);
  assign sat_q = sat_out(cur.dly_q[15], prod_q);

  // Next state
  always_comb begin
    case (state)
      ST_IDLE:  state_next = q_stat.nonempty ? ST_DECAY : ST_IDLE;
      ST_DECAY: state_next = ST_PEAK;
      ST_PEAK:  state_next = ST_LEVEL;
      ST_LEVEL: state_next = ST_DIR;
      ST_DIR:   state_next = ST_RAMP;
      ST_RAMP:  state_next = ST_CLAMP;
      ST_CLAMP: state_next = ST_APPLY;
      ST_APPLY: state_next = ST_DONE;
      ST_DONE: begin
        if (!out_free) begin
          state_next = ST_DONE;
        end else if (q_stat.nonempty) begin
          state_next = ST_DECAY;
        end else begin
          state_next = ST_IDLE;
        end
      end
      default:  state_next = ST_IDLE;
    endcase
  end

  // Outputs of the sequencer
  always_comb begin
    case (state)
      ST_IDLE: pop = q_stat.nonempty;
      ST_DONE: pop = out_free && q_stat.nonempty;
      default: pop = 1'b0;
    endcase
  end

  // Control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      peak     <= PEAK_INIT;
      gain     <= GAIN_INIT;
      m_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == ST_PEAK) begin
        peak <= env_new;
      end
      if (state == ST_CLAMP) begin
        gain <= g_new;
      end
      if (deliver) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    if (pop) begin
      cur <= head;
    end
    if (state == ST_DECAY || state == ST_LEVEL || state == ST_RAMP ||
        state == ST_APPLY) begin
      prod <= mul_p;
    end
    if (state == ST_APPLY) begin
      prod_q <= {32'b0, mag_dq} * {16'b0, gain};
    end
    if (state == ST_DIR) begin
      over <= (prod[47:0] >= {10'b0, cfg.target_level, 22'b0});
    end
    if (deliver) begin
      m_tdata <= {gain, sat_q, sat_i};
    end
  end

endmodule

// ----- bench/iqla_checker.sv -----
`timescale 1ns / 1ps

module iqla_checker import iqla_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              s_tvalid,
  input  logic              s_tready,
  input  logic [31:0]       s_tdata,    // [15:0] in_i, [31:16] in_q
  input  logic              m_tvalid,
  input  logic              m_tready,
  input  logic [63:0]       m_tdata,    // [15:0] out_i, [31:16] out_q, [63:32] gain_now
  input  logic              cfg_valid,
  input  logic              cfg_ready,
  input  logic [CFG_IW-1:0] cfg_index,
  input  logic [31:0]       cfg_data,
  output int                mismatches,
  output int                pending
);

  // Same bit layout as m_tdata
  typedef struct packed {
    logic [31:0] gain;
    logic [15:0] out_q;
    logic [15:0] out_i;
  } agc_out_t;

  localparam logic [63:0] HALF_Q30 = 64'd1 << 29;
  localparam logic [63:0] HALF_Q22 = 64'd1 << 21;

  // Predictor state
  logic [15:0] hist_i [DELAY_DEPTH];
  logic [15:0] hist_q [DELAY_DEPTH];
  int unsigned wr_ptr;
  int unsigned rd_ptr;
  logic [31:0] peak_env;
  logic [31:0] gain_reg;
  cfg_t        regs;

  agc_out_t agc_expected[$];
  agc_out_t got;
  agc_out_t want;

  // Q2.30 factor, round half up
  function automatic logic [63:0] mul_q30(input logic [63:0] a, input logic [63:0] f);
    return (a * f + HALF_Q30) >> 30;
  endfunction

  // Q1.15 sample times Q10.22 gain, ties away from zero, saturated
  function automatic logic [15:0] scale_sample(input logic [15:0] raw, input logic [31:0] g);
    logic [63:0] mag;
    logic [63:0] prod;
    mag  = raw[15] ? 64'd65536 - 64'(raw) : 64'(raw);
    prod = (mag * 64'(g) + HALF_Q22) >> 22;
    if (raw[15]) begin
      if (prod > 64'd32768) prod = 64'd32768;
      return 16'(64'd65536 - prod);
    end
    if (prod > 64'd32767) prod = 64'd32767;
    return prod[15:0];
  endfunction

  // One sample through envelope, gain loop and delay line
  function automatic agc_out_t advance_agc(input logic [15:0] smp_i, input logic [15:0] smp_q);
    logic [63:0] mag;
    logic [63:0] env;
    logic [63:0] g;
    agc_out_t    r;
    mag = smp_i[15] ? 64'd65536 - 64'(smp_i) : 64'(smp_i);
    hist_i[wr_ptr] = smp_i;
    hist_q[wr_ptr] = smp_q;

    // peak jumps up, otherwise decays
    if (mag > 64'(peak_env)) begin
      env = mag;
    end else begin
      env = mul_q30(64'(peak_env), 64'(regs.envelope_decay));
      if (env > 64'hFFFF) env = 64'hFFFF;
    end
    peak_env = env[31:0];

    // attack once envelope*gain reaches target, release below it
    if (env * 64'(gain_reg) >= (64'(regs.target_level) << 22))
      g = mul_q30(64'(gain_reg), 64'(regs.attack_ramp));
    else
      g = mul_q30(64'(gain_reg), 64'(regs.release_ramp));
    if (g > 64'(regs.max_gain)) g = 64'(regs.max_gain);
    if (g < 64'(GAIN_FLOOR)) g = 64'(GAIN_FLOOR);
    gain_reg = g[31:0];

    r.out_i = scale_sample(hist_i[rd_ptr], gain_reg);
    r.out_q = scale_sample(hist_q[rd_ptr], gain_reg);
    r.gain  = gain_reg;
    wr_ptr  = (wr_ptr == DELAY_DEPTH - 1) ? 0 : wr_ptr + 1;
    rd_ptr  = (rd_ptr == DELAY_DEPTH - 1) ? 0 : rd_ptr + 1;
    return r;
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < DELAY_DEPTH; k++) begin
        hist_i[k] = STORE_FILL;
        hist_q[k] = STORE_FILL;
      end
      wr_ptr   = DELAY_DEPTH - 1;
      rd_ptr   = 0;
      peak_env = 32'(PEAK_INIT);
      gain_reg = GAIN_INIT;
      regs.attack_ramp    = ATTACK_INIT;
      regs.release_ramp   = RELEASE_INIT;
      regs.envelope_decay = DECAY_INIT;
      regs.max_gain       = MAXG_INIT;
      regs.target_level   = TARGET_INIT;
      agc_expected.delete();
      mismatches = 0;
    end else begin
      // register writes, unknown indexes dropped
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_ATTACK:  regs.attack_ramp    = cfg_data[30:0];
          REG_RELEASE: regs.release_ramp   = cfg_data[30:0];
          REG_DECAY:   regs.envelope_decay = cfg_data[30:0];
          REG_MAXG:    regs.max_gain       = cfg_data;
          REG_TARGET:  regs.target_level   = cfg_data[15:0];
          default: ;
        endcase
      end

      if (s_tvalid && s_tready)
        agc_expected.push_back(advance_agc(s_tdata[15:0], s_tdata[31:16]));

      // compare each result with the oldest prediction
      if (m_tvalid && m_tready) begin
        got = m_tdata;
        if (agc_expected.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("[%0t] unexpected result: out_i %0d out_q %0d gain %0d", $realtime,
                     $signed(got.out_i), $signed(got.out_q), got.gain);
        end else begin
          want = agc_expected.pop_front();
          if (got.out_i != want.out_i || got.out_q != want.out_q || got.gain != want.gain) begin
            mismatches++;
            if (mismatches <= 10)
              $display("[%0t] result mismatch: expected i %0d q %0d gain %0d, got i %0d q %0d gain %0d",
                       $realtime, $signed(want.out_i), $signed(want.out_q), want.gain,
                       $signed(got.out_i), $signed(got.out_q), got.gain);
          end
        end
      end
    end
    pending <= agc_expected.size();
  end

endmodule

// ----- bench/tb.sv -----
`timescale 1ns / 1ps

module tb;
  import iqla_pkg::*;

  localparam int CYCLE_LIMIT     = 500000;
  localparam int ITEMS_PER_PHASE = 280;

  // indexes past the register list, writes are dropped
  localparam logic [CFG_IW-1:0] IDX_SPARE_LO = 3'd5;
  localparam logic [CFG_IW-1:0] IDX_SPARE_HI = 3'd7;

  typedef enum {AMP_FULL, AMP_QUIET, AMP_MID, AMP_EDGE} amp_t;

  // Directed samples, {q, i}
  localparam logic [31:0] DIRECTED [20] = '{
    32'h0000_0000, 32'h8000_7FFF, 32'h7FFF_8000, 32'h0001_FFFF, 32'hFFFF_0001,
    32'h7FFF_7FFF, 32'h8000_8000, 32'h8000_0000, 32'hC000_4000, 32'h4000_C000,
    32'hAAAA_5555, 32'h5555_AAAA, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000,
    32'h0000_0000, 32'h0000_0000, 32'h0148_0148, 32'hFEB8_FEB8, 32'h7FFF_8000
  };

  logic              clk       = 1'b0;
  logic              rst       = 1'b1;
  logic              s_tvalid  = 1'b0;
  logic [31:0]       s_tdata   = '0;
  logic              m_tready  = 1'b0;
  logic              cfg_valid = 1'b0;
  logic [CFG_IW-1:0] cfg_index = REG_ATTACK;
  logic [31:0]       cfg_data  = '0;
  logic              s_tready;
  logic              m_tvalid;
  logic [63:0]       m_tdata;
  logic              cfg_ready;

  int mismatches;
  int pending;
  int tx_idle_pct = 0;
  int rx_idle_pct = 0;
  int cycles      = 0;

  iq_lookahead_agc_top u_dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  iqla_checker u_chk (
    .clk        (clk),
    .rst        (rst),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .mismatches (mismatches),
    .pending    (pending)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  // receiver stalls
  always @(posedge clk) begin
    m_tready <= ($urandom_range(99) >= rx_idle_pct);
  end

  // run watchdog
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  function automatic logic [15:0] pick_sample(input amp_t cls);
    case (cls)
      AMP_QUIET: return 16'($urandom_range(512)) - 16'd256;
      AMP_MID:   return 16'($urandom_range(8192)) - 16'd4096;
      AMP_EDGE: begin
        case ($urandom_range(3))
          0:       return 16'h8000;
          1:       return 16'h7FFF;
          2:       return 16'hFFFF;
          default: return 16'h0000;
        endcase
      end
      default:   return 16'($urandom);
    endcase
  endfunction

  // valid stays high across back-to-back items
  task automatic send_sample(input logic [15:0] smp_i, input logic [15:0] smp_q);
    while ($urandom_range(99) < tx_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {smp_q, smp_i};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
  endtask

  task automatic drain_results();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  task automatic settle();
    drain_results();
    repeat (12) @(posedge clk);
  endtask

  task automatic put_reg(input logic [CFG_IW-1:0] idx, input logic [31:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
  endtask

  task automatic load_settings(input logic [31:0] att, input logic [31:0] rel,
                               input logic [31:0] dec, input logic [31:0] maxg,
                               input logic [31:0] tgt);
    put_reg(REG_ATTACK, att);
    put_reg(REG_RELEASE, rel);
    put_reg(REG_DECAY, dec);
    put_reg(REG_MAXG, maxg);
    put_reg(REG_TARGET, tgt);
    put_reg($urandom_range(1) ? IDX_SPARE_LO : IDX_SPARE_HI, $urandom);
    cfg_valid <= 1'b0;
  endtask

  // bursts with a fixed amplitude class on each channel so the gain loop settles and swings
  task automatic run_random(input int n, input int hold_at);
    int   seg_left;
    amp_t cls_i;
    amp_t cls_q;
    seg_left = 0;
    cls_i    = AMP_FULL;
    cls_q    = AMP_FULL;
    for (int k = 0; k < n; k++) begin
      if (k == hold_at) drain_results();
      if (seg_left == 0) begin
        seg_left = $urandom_range(60, 8);
        cls_i    = amp_t'($urandom_range(3));
        cls_q    = amp_t'($urandom_range(3));
      end
      send_sample(pick_sample(cls_i), pick_sample(cls_q));
      seg_left--;
    end
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // sender idles less than receiver
    tx_idle_pct = 25;
    rx_idle_pct = 47;
    foreach (DIRECTED[k]) send_sample(DIRECTED[k][15:0], DIRECTED[k][31:16]);
    run_random(ITEMS_PER_PHASE, -1);

    // attack at one, every other setting at the top of its range with bits beyond the field set, decay above one
    settle();
    load_settings(32'h4000_0000, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    run_random(ITEMS_PER_PHASE, -1);

    // receiver idles less than sender
    tx_idle_pct = 47;
    rx_idle_pct = 25;

    // bottom of every range but release, which is one, max gain below the floor
    settle();
    load_settings(32'd0, 32'h4000_0000, 32'd0, 32'd0, 32'd0);
    run_random(ITEMS_PER_PHASE, -1);

    // realistic ramps, with a full drain halfway through
    settle();
    load_settings(32'h4000_0000 - $urandom_range(1 << 22), 32'h4000_0000 + $urandom_range(1 << 22),
                  32'h4000_0000 - $urandom_range(1 << 20), $urandom_range(32'h4000_0000, 41943),
                  $urandom_range(32768));
    run_random(ITEMS_PER_PHASE, ITEMS_PER_PHASE / 2);

    // no idling from here on
    tx_idle_pct = 0;
    rx_idle_pct = 0;

    settle();
    load_settings($urandom, $urandom, $urandom, $urandom, $urandom);
    run_random(ITEMS_PER_PHASE, -1);

    settle();
    load_settings(ATTACK_INIT, RELEASE_INIT, DECAY_INIT, 32'd41943, $urandom_range(32768));
    run_random(ITEMS_PER_PHASE, -1);

    drain_results();
    repeat (20) @(posedge clk);
    if (mismatches == 0 && pending == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
design/iqla_pkg.sv
design/iqla_front.sv
design/iqla_queue.sv
design/iqla_back.sv
design/iq_lookahead_agc_top.sv
bench/iqla_checker.sv
bench/tb.sv
